// ----- hw/rtl/msd_pkg.sv -----
package msd_pkg;

  localparam int unsigned NumSw  = 16;
  localparam int unsigned IdxW   = $clog2(NumSw);
  localparam int unsigned NumPr  = NumSw / 2;
  localparam int unsigned CountW = 8;
  localparam int unsigned TicksW = 8;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    PhOpen    = 2'h0,
    PhClosed  = 2'h1,
    PhOpening = 2'h2,
    PhClosing = 2'h3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPresent  = 3'd0,
    CfgPair     = 3'd1,
    CfgWaitMode = 3'd2,
    CfgNotify   = 3'd3,
    CfgClosing  = 3'd4,
    CfgOpening  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic              mode;
    logic [NumSw-1:0]  change_bits;
  } in_item_t;

  typedef struct packed {
    logic [NumSw-1:0] debounced_bits;
    logic [NumSw-1:0] notify_bits;
    logic [NumSw-1:0] raw_bits;
  } out_item_t;

  // saturate a tick setting to the countdown width
  function automatic logic [CountW-1:0] sat_count(logic [TicksW-1:0] ticks);
    logic [TicksW+CountW-1:0] wide;
    logic [TicksW+CountW-1:0] lim;
    begin
      wide = (TicksW+CountW)'(ticks);
      lim  = (TicksW+CountW)'({CountW{1'b1}});
      if (wide > lim) begin
        sat_count = {CountW{1'b1}};
      end else begin
        sat_count = wide[CountW-1:0];
      end
    end
  endfunction

endpackage

// ----- hw/rtl/multi_switch_debouncer_core.sv -----
// Switch debouncer core: one shared update step visits one switch position a cycle.
// After an item is accepted, the position sequencer runs 16 position steps, then the
// result is loaded into the output register. The input stalls until then: while the
// position sequencer runs and while the finished result still waits for a full
// output register. Reset clears configuration, raw and debounced images, all
// countdowns, and puts every switch in the closed phase.
module multi_switch_debouncer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  msd_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output msd_pkg::out_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic [msd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [msd_pkg::CfgW-1:0]      cfg_wdata_i
);

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StDone
  } state_e;

  state_e state_q;

  logic [msd_pkg::NumSw-1:0]  present_q, wait_q, notify_q;
  logic [msd_pkg::NumPr-1:0]  pair_q;
  logic [msd_pkg::TicksW-1:0] close_ticks_q, open_ticks_q;

  logic [msd_pkg::NumSw-1:0]  raw_q, db_q, notes_q, chg_q;
  logic [msd_pkg::NumSw-1:0]  db_d, notes_d;
  logic                       mode_q;
  logic [msd_pkg::IdxW-1:0]   idx_q;

  msd_pkg::phase_e            phase_q [msd_pkg::NumSw];
  logic [msd_pkg::CountW-1:0] count_q [msd_pkg::NumSw];
  msd_pkg::phase_e            ph_d;
  logic [msd_pkg::CountW-1:0] cnt_d;

  logic                       out_valid_q;
  msd_pkg::out_item_t         out_item_q;

  logic in_acc;
  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // shared per-position update step
  logic [msd_pkg::IdxW-1:0]   idx_lo, idx_hi;
  logic [msd_pkg::CountW-1:0] close_cnt, open_cnt, cnt_cur;
  msd_pkg::phase_e            ph_cur, end_ph;
  logic raw_bit, wait_bit, button, pair_act, counting, end_put;
  logic put, put_val, tell;
  logic [1:0] pr_on, pr_cur;

  assign idx_lo    = {idx_q[msd_pkg::IdxW-1:1], 1'b0};
  assign idx_hi    = {idx_q[msd_pkg::IdxW-1:1], 1'b1};
  assign close_cnt = msd_pkg::sat_count(close_ticks_q);
  assign open_cnt  = msd_pkg::sat_count(open_ticks_q);
  assign ph_cur    = phase_q[idx_q];
  assign cnt_cur   = count_q[idx_q];
  assign raw_bit   = raw_q[idx_q];
  assign wait_bit  = wait_q[idx_q];
  assign pair_act  = pair_q[idx_q[msd_pkg::IdxW-1:1]] && present_q[idx_lo];
  assign button    = present_q[idx_q] && !pair_act;
  assign counting  = (ph_cur == msd_pkg::PhOpening) || (ph_cur == msd_pkg::PhClosing);
  assign end_ph    = raw_bit ? msd_pkg::PhOpen : msd_pkg::PhClosed;
  assign end_put   = (ph_cur == msd_pkg::PhOpening) ? (raw_bit == wait_bit)
                                                    : (raw_bit != wait_bit);
  assign pr_on     = {raw_q[idx_hi], raw_q[idx_lo]};
  assign pr_cur    = {db_q[idx_hi], db_q[idx_lo]};

  always_comb begin
    ph_d    = ph_cur;
    cnt_d   = cnt_cur;
    db_d    = db_q;
    notes_d = notes_q;
    put     = 1'b0;
    put_val = 1'b0;
    tell    = 1'b0;
    if (mode_q) begin
      if (button && counting) begin
        if (cnt_cur <= msd_pkg::CountW'(1)) begin
          ph_d    = end_ph;
          cnt_d   = '0;
          put     = end_put;
          put_val = raw_bit;
          tell    = 1'b1;
        end else begin
          cnt_d = cnt_cur - msd_pkg::CountW'(1);
        end
      end
    end else if (chg_q[idx_q] && button) begin
      unique case (ph_cur)
        msd_pkg::PhOpen: begin
          if (!raw_bit) begin
            put_val = 1'b0;
            tell    = 1'b1;
            if (close_cnt == '0) begin
              put  = 1'b1;
              ph_d = msd_pkg::PhClosed;
            end else begin
              put   = !wait_bit;
              ph_d  = msd_pkg::PhClosing;
              cnt_d = close_cnt;
            end
          end else begin
            put     = 1'b1;
            put_val = 1'b1;
          end
        end
        msd_pkg::PhClosed: begin
          if (raw_bit) begin
            put_val = 1'b1;
            tell    = 1'b1;
            if (open_cnt == '0) begin
              put  = 1'b1;
              ph_d = msd_pkg::PhOpen;
            end else begin
              put   = !wait_bit;
              ph_d  = msd_pkg::PhOpening;
              cnt_d = open_cnt;
            end
          end else begin
            put     = 1'b1;
            put_val = 1'b0;
          end
        end
        msd_pkg::PhOpening: begin
          if (open_cnt == '0) begin
            ph_d    = end_ph;
            cnt_d   = '0;
            put     = end_put;
            put_val = raw_bit;
            tell    = 1'b1;
          end else begin
            cnt_d = open_cnt;
          end
        end
        default: begin
          if (close_cnt == '0) begin
            ph_d    = end_ph;
            cnt_d   = '0;
            put     = end_put;
            put_val = raw_bit;
            tell    = 1'b1;
          end else begin
            cnt_d = close_cnt;
          end
        end
      endcase
    end
    if (put) begin
      db_d[idx_q] = put_val;
      if (tell && notify_q[idx_q]) begin
        notes_d[idx_q] = 1'b1;
      end
    end
    // pair latches 01 / 10, visited at its even position
    if (!mode_q && !idx_q[0] && pair_act && (chg_q[idx_hi] || chg_q[idx_lo])) begin
      if ((pr_on == 2'b01 || pr_on == 2'b10) && pr_cur != pr_on) begin
        db_d[idx_lo] = pr_on[0];
        db_d[idx_hi] = pr_on[1];
        if (notify_q[idx_lo]) begin
          notes_d[idx_lo] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q     <= '0;
      pair_q        <= '0;
      wait_q        <= '0;
      notify_q      <= '0;
      close_ticks_q <= '0;
      open_ticks_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (msd_pkg::cfg_idx_e'(cfg_idx_i))
        msd_pkg::CfgPresent:  present_q     <= cfg_wdata_i[msd_pkg::NumSw-1:0];
        msd_pkg::CfgPair:     pair_q        <= cfg_wdata_i[msd_pkg::NumPr-1:0];
        msd_pkg::CfgWaitMode: wait_q        <= cfg_wdata_i[msd_pkg::NumSw-1:0];
        msd_pkg::CfgNotify:   notify_q      <= cfg_wdata_i[msd_pkg::NumSw-1:0];
        msd_pkg::CfgClosing:  close_ticks_q <= cfg_wdata_i[msd_pkg::TicksW-1:0];
        msd_pkg::CfgOpening:  open_ticks_q  <= cfg_wdata_i[msd_pkg::TicksW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      raw_q       <= '0;
      db_q        <= '0;
      notes_q     <= '0;
      mode_q      <= 1'b0;
      chg_q       <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      for (int i = 0; i < msd_pkg::NumSw; i++) begin
        phase_q[i] <= msd_pkg::PhClosed;
        count_q[i] <= '0;
      end
    end else begin
      if (state_q == StDone && (!out_valid_q || !out_stall_i)) begin
        out_valid_q               <= 1'b1;
        out_item_q.debounced_bits <= db_q;
        out_item_q.notify_bits    <= notes_q;
        out_item_q.raw_bits       <= raw_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            mode_q  <= in_item_i.mode;
            chg_q   <= in_item_i.change_bits;
            notes_q <= '0;
            idx_q   <= '0;
            if (!in_item_i.mode) begin
              raw_q <= raw_q ^ in_item_i.change_bits;
            end
            state_q <= StRun;
          end
        end
        StRun: begin
          phase_q[idx_q] <= ph_d;
          count_q[idx_q] <= cnt_d;
          db_q           <= db_d;
          notes_q        <= notes_d;
          idx_q          <= idx_q + msd_pkg::IdxW'(1);
          if (idx_q == msd_pkg::IdxW'(msd_pkg::NumSw - 1)) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ----- hw/rtl/msd_checker.sv -----
module msd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input msd_pkg::out_item_t          out_item_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // the sequencer stays busy after taking an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("input taken during item processing");

  // a new result only appears out of a busy period
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without item in progress");

  // leaving busy always posts a result
  a_free_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("item finished without result");

endmodule

bind multi_switch_debouncer_core msd_checker u_msd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
